>>> hw/rtl/pbce_pkg.sv
// Shared constants and character class helpers for the byte-count line scanner.
package pbce_pkg;

   // Fixed widths of the beat fields
   localparam int unsigned DataW  = 8;
   localparam int unsigned CountW = 48;

   // Characters of the pattern
   localparam logic [DataW-1:0] CharOpen  = 8'h28;  // '('
   localparam logic [DataW-1:0] CharZero  = 8'h30;  // '0'
   localparam logic [DataW-1:0] CharNine  = 8'h39;  // '9'
   localparam logic [DataW-1:0] CharB     = 8'h62;  // 'b'
   localparam logic [DataW-1:0] CharY     = 8'h79;  // 'y'
   localparam logic [DataW-1:0] CharT     = 8'h74;  // 't'
   localparam logic [DataW-1:0] CharE     = 8'h65;  // 'e'
   localparam logic [DataW-1:0] CharSpace = 8'h20;
   localparam logic [DataW-1:0] CharTab   = 8'h09;  // first of tab .. carriage return
   localparam logic [DataW-1:0] CharCr    = 8'h0d;
   localparam logic [DataW-1:0] CharUpA   = 8'h41;
   localparam logic [DataW-1:0] CharUpZ   = 8'h5a;
   localparam logic [DataW-1:0] CaseBit   = 8'h20;

   // Space, tab, line feed, vertical tab, form feed, carriage return
   function automatic logic is_space(input logic [DataW-1:0] c);
      return (c == CharSpace) || ((c >= CharTab) && (c <= CharCr));
   endfunction

   function automatic logic is_digit(input logic [DataW-1:0] c);
      return (c >= CharZero) && (c <= CharNine);
   endfunction

   // ASCII-only fold to lower case
   function automatic logic [DataW-1:0] to_lower(input logic [DataW-1:0] c);
      return ((c >= CharUpA) && (c <= CharUpZ)) ? (c | CaseBit) : c;
   endfunction

   // Control for one scanner step
   typedef struct packed {
      logic step;
      logic last;
   } scan_ctl_type;

endpackage

>>> hw/rtl/pbce_scan.sv
// Pattern phase machine and saturating decimal accumulator, one character per step.
module pbce_scan #(
   parameter int unsigned VALUE_BITS = 48
) (
   input  logic                        clock,
   input  logic                        reset,
   input  pbce_pkg::scan_ctl_type      ctl,
   input  logic [pbce_pkg::DataW-1:0]  data_byte,
   output logic                        found,
   output logic [VALUE_BITS-1:0]       value
);

   typedef enum logic [2:0] {
      PH_SEEK, PH_OPENED, PH_DIGITS, PH_AFTERNUM,
      PH_GOT_B, PH_GOT_Y, PH_GOT_T, PH_DONE
   } phase_type;

   phase_type             phase_ff, phase_in, phase_nxt, seek_ph;
   logic [VALUE_BITS-1:0] accum_ff, accum_in, accum_nxt, accum_mac;
   logic [VALUE_BITS+3:0] mac_wide;
   logic [3:0]            digit;
   logic [pbce_pkg::DataW-1:0] lc;
   logic                  ws, dig;

   assign lc    = pbce_pkg::to_lower(data_byte);
   assign ws    = pbce_pkg::is_space(data_byte);
   assign dig   = pbce_pkg::is_digit(data_byte);
   assign digit = data_byte[3:0];

   // Retry the failing character as a possible open parenthesis
   assign seek_ph = (data_byte == pbce_pkg::CharOpen) ? PH_OPENED : PH_SEEK;

   // Multiply by ten as two shifts and add, saturate on carry out
   assign mac_wide = ({4'b0000, accum_ff} << 3) + ({4'b0000, accum_ff} << 1)
                   + {{VALUE_BITS{1'b0}}, digit};
   assign accum_mac = (|mac_wide[VALUE_BITS+3:VALUE_BITS]) ? {VALUE_BITS{1'b1}}
                                                           : mac_wide[VALUE_BITS-1:0];

   // Next phase and accumulator for the current character
   always_comb begin
      phase_nxt = phase_ff;
      accum_nxt = accum_ff;
      unique case (phase_ff)
         PH_SEEK: begin
            phase_nxt = seek_ph;
         end
         PH_OPENED: begin
            if (ws) begin
               phase_nxt = PH_OPENED;
            end else if (dig) begin
               accum_nxt = {{(VALUE_BITS-4){1'b0}}, digit};
               phase_nxt = PH_DIGITS;
            end else begin
               phase_nxt = seek_ph;
            end
         end
         PH_DIGITS: begin
            if (dig) begin
               accum_nxt = accum_mac;
            end else if (ws) begin
               phase_nxt = PH_AFTERNUM;
            end else if (lc == pbce_pkg::CharB) begin
               phase_nxt = PH_GOT_B;
            end else begin
               phase_nxt = seek_ph;
            end
         end
         PH_AFTERNUM: begin
            if (ws) begin
               phase_nxt = PH_AFTERNUM;
            end else if (lc == pbce_pkg::CharB) begin
               phase_nxt = PH_GOT_B;
            end else begin
               phase_nxt = seek_ph;
            end
         end
         PH_GOT_B: begin
            phase_nxt = (lc == pbce_pkg::CharY) ? PH_GOT_Y : seek_ph;
         end
         PH_GOT_Y: begin
            phase_nxt = (lc == pbce_pkg::CharT) ? PH_GOT_T : seek_ph;
         end
         PH_GOT_T: begin
            phase_nxt = (lc == pbce_pkg::CharE) ? PH_DONE : seek_ph;
         end
         PH_DONE: begin
            phase_nxt = PH_DONE;
         end
         default: begin
            phase_nxt = seek_ph;
         end
      endcase
   end

   // Report on the last character of the line
   assign found = (phase_nxt == PH_DONE);
   assign value = found ? accum_nxt : '0;

   // Advance on a step, rearm at line end
   always_comb begin
      phase_in = phase_ff;
      accum_in = accum_ff;
      if (ctl.step) begin
         if (ctl.last) begin
            phase_in = PH_SEEK;
            accum_in = '0;
         end else begin
            phase_in = phase_nxt;
            accum_in = accum_nxt;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SEEK;
         accum_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         accum_ff <= accum_in;
      end
   end

endmodule

>>> hw/rtl/paren_byte_count_extract.sv
// Top level of the parenthesized byte-count line scanner.
//
//   channel | direction | ports                               | beat
//   req     | in        | req_valid/ready, data_byte, is_last | one character of a line
//   rsp     | out       | rsp_valid/ready, found, byte_count  | one per line, on its last char
//
// One character enters per cycle while req_ready is high; it is held in the input register
// and scanned there, and a line's result is then loaded into the output register for rsp_valid.
// The scan step is one phase update plus a multiply-by-ten add of the accumulator.
// A stalled result holds in the output register; only a last character then waits.
// Reset is synchronous and returns the scan to seeking an open parenthesis.
module paren_byte_count_extract #(
   parameter int unsigned VALUE_BITS = 48
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [pbce_pkg::DataW-1:0]    req_data_byte,
   input  logic                          req_is_last,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_found,
   output logic [pbce_pkg::CountW-1:0]   rsp_byte_count
);

   logic                         in_valid_ff, in_valid_in;
   logic [pbce_pkg::DataW-1:0]   in_byte_ff;
   logic                         in_last_ff;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_found_ff;
   logic [pbce_pkg::CountW-1:0]  rsp_count_ff;
   logic                         step, req_take;
   pbce_pkg::scan_ctl_type       ctl;
   logic                         scan_found;
   logic [VALUE_BITS-1:0]        scan_value;
   logic [pbce_pkg::CountW-1:0]  scan_count;

   // Scan the held character unless a line result would overrun a stalled one
   assign step      = in_valid_ff && (!in_last_ff || !rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || step;
   assign req_take  = req_valid && req_ready;
   assign ctl       = '{step: step, last: in_last_ff};

   pbce_scan #(.VALUE_BITS(VALUE_BITS)) u_scan (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .data_byte (in_byte_ff),
      .found     (scan_found),
      .value     (scan_value)
   );

   // Fit the accumulator into the fixed count field
   generate
      if (VALUE_BITS >= pbce_pkg::CountW) begin : g_trunc
         assign scan_count = scan_value[pbce_pkg::CountW-1:0];
      end else begin : g_ext
         assign scan_count = {{(pbce_pkg::CountW-VALUE_BITS){1'b0}}, scan_value};
      end
   endgenerate

   // Input register: load on accept, drop once scanned
   assign in_valid_in = req_take ? 1'b1 : (step ? 1'b0 : in_valid_ff);

   // Output register: load on a line end, drop once taken
   assign rsp_valid_in = (step && in_last_ff) ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_data_byte;
         in_last_ff <= req_is_last;
      end
      if (step && in_last_ff) begin
         rsp_found_ff <= scan_found;
         rsp_count_ff <= scan_count;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_byte_count = rsp_count_ff;

   // A line end that is scanned always leaves a result ready
   a_last_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      (step && in_last_ff) |=> rsp_valid)
      else $error("line end scanned without a result");

   // A held character that cannot step stays put
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !step) |=> (in_valid_ff && $stable(in_byte_ff) && $stable(in_last_ff)))
      else $error("input register changed while stalled");

   // No match reports a zero count
   a_zero_when_absent: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |-> (rsp_byte_count == '0))
      else $error("count nonzero without a match");

endmodule

>>> sim/paren_byte_count_extract_tb.sv
// Self-checking testbench for the parenthesized byte-count line scanner.
`timescale 1ns / 100ps

module paren_byte_count_extract_tb;

   localparam int ValueBits   = 48;
   localparam int BeatTarget  = 1900;
   localparam int DrainMark   = 1300;   // beat index where the sender waits for a drain
   localparam int LongHoldAt  = 700;    // beats taken before the long receiver hold
   localparam int LongHoldLen = 300;
   localparam logic [63:0] AccMax = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - ValueBits);

   typedef enum logic [2:0] {
      SEEK_OPEN, IN_PAREN, IN_DIGITS, AFTER_DIGITS, SAW_B, SAW_Y, SAW_T, MATCHED
   } scan_phase_type;

   typedef struct {
      logic [pbce_pkg::DataW-1:0] data;
      logic                       last;
      bit                         drain_first;
   } char_beat_type;

   typedef struct {
      logic                        found;
      logic [pbce_pkg::CountW-1:0] byte_count;
   } line_result_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_ready;
   logic [pbce_pkg::DataW-1:0]  req_data_byte = '0;
   logic                        req_is_last = 1'b0;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   logic                        rsp_found;
   logic [pbce_pkg::CountW-1:0] rsp_byte_count;

   char_beat_type   char_queue[$];
   line_result_type line_results[$];
   logic [pbce_pkg::DataW-1:0] line_text[$];
   logic [pbce_pkg::DataW-1:0] word_chars[4] = '{pbce_pkg::CharB, pbce_pkg::CharY,
                                                 pbce_pkg::CharT, pbce_pkg::CharE};

   scan_phase_type  phase_now = SEEK_OPEN;
   logic [63:0]     count_now = '0;
   int              beats_taken = 0;
   int              send_idle = 0;
   int              send_calm = 0;
   int              recv_hold = 0;
   int              recv_calm = 0;
   bit              long_hold_done = 1'b0;
   int              mismatch_count = 0;
   line_result_type oldest_line;

   paren_byte_count_extract #(.VALUE_BITS(ValueBits)) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data_byte  (req_data_byte),
      .req_is_last    (req_is_last),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_found      (rsp_found),
      .rsp_byte_count (rsp_byte_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ---------------- line scanner prediction ----------------

   function automatic bit is_blank(input logic [pbce_pkg::DataW-1:0] c);
      return (c == pbce_pkg::CharSpace) ||
             ((c >= pbce_pkg::CharTab) && (c <= pbce_pkg::CharCr));
   endfunction

   function automatic bit is_numeral(input logic [pbce_pkg::DataW-1:0] c);
      return (c >= pbce_pkg::CharZero) && (c <= pbce_pkg::CharNine);
   endfunction

   function automatic logic [pbce_pkg::DataW-1:0] fold_case(
         input logic [pbce_pkg::DataW-1:0] c);
      return ((c >= pbce_pkg::CharUpA) && (c <= pbce_pkg::CharUpZ)) ?
             (c ^ pbce_pkg::CaseBit) : c;
   endfunction

   // Saturate instead of wrapping when another digit would overflow
   function automatic logic [63:0] add_digit(input logic [63:0] acc, input logic [63:0] d);
      if (acc > (AccMax - d) / 10)
         return AccMax;
      return acc * 10 + d;
   endfunction

   // Advance the pattern scan by one character
   function automatic void scan_char(input logic [pbce_pkg::DataW-1:0] c);
      logic [pbce_pkg::DataW-1:0] lc;
      scan_phase_type             retry;
      lc = fold_case(c);
      // a failing character is tried again as an open parenthesis
      retry = (c == pbce_pkg::CharOpen) ? IN_PAREN : SEEK_OPEN;
      case (phase_now)
         IN_PAREN: begin
            if (is_numeral(c)) begin
               count_now = 64'(c - pbce_pkg::CharZero);
               phase_now = IN_DIGITS;
            end else if (!is_blank(c)) begin
               phase_now = retry;
            end
         end
         IN_DIGITS: begin
            if (is_numeral(c)) count_now = add_digit(count_now, 64'(c - pbce_pkg::CharZero));
            else if (is_blank(c)) phase_now = AFTER_DIGITS;
            else if (lc == pbce_pkg::CharB) phase_now = SAW_B;
            else phase_now = retry;
         end
         AFTER_DIGITS: begin
            if (lc == pbce_pkg::CharB) phase_now = SAW_B;
            else if (!is_blank(c)) phase_now = retry;
         end
         SAW_B: phase_now = (lc == pbce_pkg::CharY) ? SAW_Y : retry;
         SAW_Y: phase_now = (lc == pbce_pkg::CharT) ? SAW_T : retry;
         SAW_T: phase_now = (lc == pbce_pkg::CharE) ? MATCHED : retry;
         MATCHED: ;
         default: phase_now = retry;
      endcase
   endfunction

   // ---------------- stimulus helpers ----------------

   function automatic logic [pbce_pkg::DataW-1:0] blank_char();
      return ($urandom_range(0, 5) == 5) ? pbce_pkg::CharSpace
                                         : 8'(pbce_pkg::CharTab + $urandom_range(0, 4));
   endfunction

   function automatic logic [pbce_pkg::DataW-1:0] any_char();
      case ($urandom_range(0, 9))
         0: return pbce_pkg::CharOpen;
         1, 2: return 8'(pbce_pkg::CharZero + $urandom_range(0, 9));
         3: return blank_char();
         4: return word_chars[$urandom_range(0, 3)] ^
                   ($urandom_range(0, 1) ? pbce_pkg::CaseBit : 8'h00);
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Gap length for either side; an occasional calm stretch has no gaps at all
   function automatic int idle_length(inout int calm);
      int roll;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      roll = $urandom_range(0, 999);
      if (roll < 5) begin
         calm = $urandom_range(40, 160);
         return 0;
      end
      if (roll < 650) return 0;
      if (roll < 960) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Build one random line: mostly the pattern with random content, some broken or noise
   task automatic compose_line();
      int    kind;
      int    digits;
      int    cut;
      string num_text;
      line_text = {};
      kind = $urandom_range(0, 99);
      if (kind < 15) begin
         repeat ($urandom_range(1, 12)) line_text.push_back(any_char());
      end else begin
         repeat ($urandom_range(0, 3)) line_text.push_back(any_char());
         line_text.push_back(pbce_pkg::CharOpen);
         repeat ($urandom_range(0, 2)) line_text.push_back(blank_char());
         if ($urandom_range(0, 29) == 0) begin
            // just at and just past the saturation point
            num_text = $urandom_range(0, 1) ? "281474976710655" : "281474976710656";
            for (int i = 0; i < num_text.len(); i++) line_text.push_back(num_text[i]);
         end else begin
            digits = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 20)
                                                 : $urandom_range(1, 6);
            repeat (digits)
               line_text.push_back(8'(pbce_pkg::CharZero + $urandom_range(0, 9)));
         end
         repeat ($urandom_range(0, 2)) line_text.push_back(blank_char());
         foreach (word_chars[i])
            line_text.push_back(word_chars[i] ^
                                ($urandom_range(0, 1) ? pbce_pkg::CaseBit : 8'h00));
         repeat ($urandom_range(0, 3)) line_text.push_back(any_char());
         // break some lines by truncation or a corrupted character
         if (kind < 40) begin
            cut = $urandom_range(0, line_text.size() - 1);
            if ($urandom_range(0, 1)) line_text = line_text[0:cut];
            else line_text[cut] = any_char();
         end
      end
   endtask

   // Queue the current line, flagging its final character
   task automatic queue_line(input bit drain_first);
      char_beat_type beat;
      foreach (line_text[i]) begin
         beat.data        = line_text[i];
         beat.last        = (i == line_text.size() - 1);
         beat.drain_first = drain_first && (i == 0);
         char_queue.push_back(beat);
      end
   endtask

   task automatic log_mismatch(input string field, input logic [63:0] want,
                               input logic [63:0] got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t: %s expected %0d got %0d", $time, field, want, got);
   endtask

   // ---------------- sender ----------------

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         // predict on every accepted beat
         if (req_valid && req_ready) begin
            scan_char(req_data_byte);
            if (req_is_last) begin
               line_results.push_back('{found: (phase_now == MATCHED),
                  byte_count: (phase_now == MATCHED) ? count_now[pbce_pkg::CountW-1:0]
                                                     : '0});
               phase_now = SEEK_OPEN;
               count_now = '0;
            end
            beats_taken <= beats_taken + 1;
         end
         // offer the next beat once the current one is gone
         if (!req_valid || req_ready) begin
            if (send_idle > 0) begin
               send_idle--;
               req_valid <= 1'b0;
            end else if (char_queue.size() != 0 &&
                         !(char_queue[0].drain_first && line_results.size() != 0)) begin
               req_valid     <= 1'b1;
               req_data_byte <= char_queue[0].data;
               req_is_last   <= char_queue[0].last;
               void'(char_queue.pop_front());
               send_idle = idle_length(send_calm);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------- receiver ----------------

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (recv_hold > 0) begin
         recv_hold--;
         rsp_ready <= 1'b0;
      end else if (!long_hold_done && beats_taken >= LongHoldAt) begin
         // hold off long enough for the scanner to back up into its input
         long_hold_done = 1'b1;
         recv_hold = LongHoldLen - 1;
         rsp_ready <= 1'b0;
      end else begin
         recv_hold = idle_length(recv_calm);
         if (recv_hold > 0) begin
            recv_hold--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // ---------------- result check ----------------

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (line_results.size() == 0) begin
            log_mismatch("unexpected result, byte_count", 64'd0, 64'(rsp_byte_count));
         end else begin
            oldest_line = line_results.pop_front();
            if (rsp_found !== oldest_line.found)
               log_mismatch("found", 64'(oldest_line.found), 64'(rsp_found));
            if (rsp_byte_count !== oldest_line.byte_count)
               log_mismatch("byte_count", 64'(oldest_line.byte_count),
                            64'(rsp_byte_count));
         end
      end
   end

   // ---------------- stimulus and end of run ----------------

   initial begin
      // uppercase word, match completed by the last character
      line_text = '{pbce_pkg::CharOpen, 8'h37, 8'h42, 8'h59, 8'h54, 8'h45};
      queue_line(1'b0);
      // zero byte, all-ones byte, repeated parenthesis, line ends mid pattern
      line_text = '{8'h00, 8'hff, pbce_pkg::CharOpen, pbce_pkg::CharOpen, pbce_pkg::CharTab,
                    8'h39, pbce_pkg::CharSpace, pbce_pkg::CharB};
      queue_line(1'b0);
      // characters after a match are ignored
      line_text = '{pbce_pkg::CharOpen, 8'h33, pbce_pkg::CharB, pbce_pkg::CharY,
                    pbce_pkg::CharT, pbce_pkg::CharE, 8'h29};
      queue_line(1'b0);
      // single-character line
      line_text = '{pbce_pkg::CharOpen};
      queue_line(1'b0);

      // random lines; wait for a full drain after the directed lines and once more later
      compose_line();
      queue_line(1'b1);
      while (char_queue.size() < BeatTarget) begin
         compose_line();
         queue_line(char_queue.size() < DrainMark &&
                    char_queue.size() + line_text.size() >= DrainMark);
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      while (char_queue.size() != 0 || req_valid) @(negedge clock);
      while (line_results.size() != 0) @(negedge clock);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Watchdog
   initial begin
      #3_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

>>> filelist.f
hw/rtl/pbce_pkg.sv
hw/rtl/pbce_scan.sv
hw/rtl/paren_byte_count_extract.sv
sim/paren_byte_count_extract_tb.sv
